// ===== rtl/pr_pkg.sv =====
// Shared types, constants and codes for the power-iteration ranking block.
package pr_pkg;

  localparam int NODE_LIMIT    = 16;
  localparam int DEF_MAX_NODES = 16;
  localparam int ROW_W         = 16;
  localparam int VAL_W         = 32;
  localparam int PROD_W        = 64;
  localparam int ACC_W         = 36;
  localparam int NODE_W        = 5;
  localparam int ITER_W        = 16;
  localparam int VTX_W         = 4;

  localparam logic [VAL_W-1:0]  Q_ONE         = 32'h8000_0000;
  localparam logic [NODE_W-1:0] RST_NODES     = 5'd16;
  localparam logic [VAL_W-1:0]  RST_TELEPORT  = 32'd322122547;
  localparam logic [VAL_W-1:0]  RST_TOLERANCE = 32'd2147;
  localparam logic [ITER_W-1:0] RST_LIMIT     = 16'd2000;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_TELEPORT   = 2'd1,
    CFG_TOLERANCE  = 2'd2,
    CFG_ITER_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_TELE_GO, S_TELE_WAIT, S_START_GO, S_START_WAIT,
    S_EDGE_GO, S_EDGE_WAIT, S_SQ, S_SUM, S_SQRT_GO, S_SQRT_WAIT, S_DECIDE,
    S_COPY, S_MAC, S_MAC_DRAIN, S_SAT, S_AVG, S_SCAN, S_EMIT, S_WAIT_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } lane_ctrl_t;

endpackage

// ===== rtl/pr_div.sv =====
// Restoring serial divider: 32-bit dividend by 5-bit divisor, one bit per cycle.
module pr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pr_pkg::VAL_W-1:0]   dividend,
  input  logic [pr_pkg::NODE_W-1:0]  divisor,
  output logic                       done,
  output logic [pr_pkg::VAL_W-1:0]   quot
);
  import pr_pkg::*;

  logic [VAL_W-1:0]  quo_r;
  logic [NODE_W:0]   rem_r;
  logic [NODE_W-1:0] div_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [NODE_W:0]   rem_sh;
  logic              ge;

  // Bring down the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem_r[NODE_W-1:0], quo_r[VAL_W-1]};
    ge     = rem_sh >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? rem_sh - {1'b0, div_r} : rem_sh;
      quo_r <= {quo_r[VAL_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/pr_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
module pr_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pr_pkg::PROD_W-1:0] radicand,
  output logic                      done,
  output logic [pr_pkg::VAL_W-1:0]  root
);
  import pr_pkg::*;

  logic [PROD_W-1:0] x_r;
  logic [35:0]       rem_r;
  logic [VAL_W-1:0]  root_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [35:0]       rem_sh;
  logic [35:0]       trial;
  logic              ge;

  // Bring down two bits and test root*4+1
  always_comb begin
    rem_sh = {rem_r[33:0], x_r[PROD_W-1:PROD_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      x_r    <= {x_r[PROD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[VAL_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/pr_lane.sv =====
// One rank lane: registered multiplier feeding a 36-bit accumulator of Q1.31 terms.
module pr_lane (
  input  logic                      clk,
  input  pr_pkg::lane_ctrl_t        ctrl,
  input  logic [pr_pkg::VAL_W-1:0]  op_a,
  input  logic [pr_pkg::VAL_W-1:0]  op_b,
  output logic [pr_pkg::PROD_W-1:0] prod,
  output logic [pr_pkg::ACC_W-1:0]  acc
);
  import pr_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;

  // Register the product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= {32'd0, op_a} * {32'd0, op_b};
    end
  end

  // Accumulate the truncated Q1.31 term
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + {{(ACC_W-VAL_W){1'b0}}, prod_r[62:31]};
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/pagerank_power_iteration.sv =====
// Power-iteration PageRank engine: row loading, sequencer, rank lanes and ordered output.
//
// Adjacency rows load at one per cycle; the row flagged last starts the run and the
// block takes no further rows until its final result has been transferred. Setup runs
// the serial divider once for D/n, once for 1/n and once per vertex for the edge term,
// then computes the first norm. Each power iteration then does a multiply-accumulate
// pass across the parallel lanes (one lane per vertex, one source vertex per cycle),
// sums the squares for the norm and runs the serial square root. Ranking emits the n
// results by a selection scan over all vertices for each one, and output also waits
// on any stall on out_ready.
// A row whose edges all fall outside the vertex count gives a single error result.
module pagerank_power_iteration #(
  parameter int MAX_NODES = pr_pkg::DEF_MAX_NODES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pr_pkg::ROW_W-1:0]    in_row_bits,
  input  logic [3:0]                  in_row_index,
  input  logic                        in_last_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pr_pkg::VTX_W-1:0]    out_vertex,
  output logic [pr_pkg::VAL_W-1:0]    out_rank_value,
  output logic [pr_pkg::ITER_W-1:0]   out_iterations_used,
  output logic                        out_limit_reached,
  output logic                        out_empty_row_error,
  output logic                        out_last_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [pr_pkg::VAL_W-1:0]    cfg_data
);
  import pr_pkg::*;

  localparam int CAP   = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
  localparam int IDX_W = $clog2(CAP);
  localparam logic [NODE_W-1:0] CAP_N = NODE_W'(CAP);

  state_t state_r, state_nxt;

  // Configuration registers
  logic [NODE_W-1:0] cfg_nodes_r;
  logic [VAL_W-1:0]  cfg_tele_r;
  logic [VAL_W-1:0]  cfg_tol_r;
  logic [ITER_W-1:0] cfg_limit_r;

  // Run parameters latched at start
  logic [NODE_W-1:0] n_r;
  logic [IDX_W-1:0]  nm1_r;
  logic [VAL_W-1:0]  d_r;
  logic [ITER_W-1:0] limit_r;
  logic [ROW_W-1:0]  mask_r;

  logic [ROW_W-1:0]  adj_r  [CAP];
  logic [VAL_W-1:0]  pt_r   [CAP];
  logic [VAL_W-1:0]  rank_r [CAP];
  logic [VAL_W-1:0]  prev_r [CAP];
  logic [VAL_W-1:0]  tele_r;

  logic [IDX_W-1:0]  cnt_r;
  logic [ITER_W-1:0] iter_r;
  logic              first_r;
  logic              mac_d_r;
  logic [PROD_W-1:0] sum_r;
  logic [VAL_W-1:0]  old_norm_r;
  logic [VAL_W-1:0]  new_norm_r;
  logic              limited_r;

  logic [CAP-1:0]    used_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_r;
  logic [VAL_W-1:0]  best_val_r;
  logic [IDX_W-1:0]  k_r;

  logic              out_valid_r;
  logic [VTX_W-1:0]  out_vertex_r;
  logic [VAL_W-1:0]  out_rank_r;
  logic [ITER_W-1:0] out_iter_r;
  logic              out_lim_r;
  logic              out_err_r;
  logic              out_last_r;

  // Derived combinational values
  logic              in_xfer;
  logic              out_xfer;
  logic [NODE_W-1:0] n_clamp;
  logic [VAL_W-1:0]  d_clamp;
  logic [ROW_W-1:0]  mask_nxt;
  logic              empty_hit;
  logic [ROW_W-1:0]  cur_row;
  logic [NODE_W-1:0] deg;
  logic              div_start;
  logic [VAL_W-1:0]  div_dvd;
  logic [NODE_W-1:0] div_dvs;
  logic              div_done;
  logic [VAL_W-1:0]  div_q;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [VAL_W-1:0]  sqrt_root;
  logic [PROD_W:0]   sum_add;
  logic [VAL_W-1:0]  norm_diff;
  logic              stop_now;
  logic              take;
  logic              last_cnt;
  lane_ctrl_t        lctl;
  logic [PROD_W-1:0] lane_prod [CAP];
  logic [ACC_W-1:0]  lane_acc  [CAP];
  logic [VAL_W-1:0]  lane_a    [CAP];
  logic [VAL_W-1:0]  lane_b    [CAP];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign last_cnt  = (cnt_r == nm1_r);

  // Clamp configuration to usable ranges
  always_comb begin
    if (cfg_nodes_r == '0) begin
      n_clamp = NODE_W'(1);
    end else if (cfg_nodes_r > CAP_N) begin
      n_clamp = CAP_N;
    end else begin
      n_clamp = cfg_nodes_r;
    end
    d_clamp = (cfg_tele_r > Q_ONE) ? Q_ONE : cfg_tele_r;
    for (int b = 0; b < ROW_W; b++) begin
      mask_nxt[b] = (NODE_W'(b) < n_clamp);
    end
  end

  // Flag any in-use row without an edge to an in-use vertex
  always_comb begin
    empty_hit = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      if ((NODE_W'(i) < n_r) && ((adj_r[i] & mask_r) == '0)) begin
        empty_hit = 1'b1;
      end
    end
  end

  // Out-degree of the row under the counter
  always_comb begin
    cur_row = adj_r[cnt_r] & mask_r;
    deg     = '0;
    for (int b = 0; b < ROW_W; b++) begin
      deg = deg + NODE_W'(cur_row[b]);
    end
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = Q_ONE;
    div_dvs   = n_r;
    case (state_r)
      S_TELE_GO: begin
        div_start = 1'b1;
        div_dvd   = d_r;
      end
      S_START_GO: begin
        div_start = 1'b1;
      end
      S_EDGE_GO: begin
        div_start = 1'b1;
        div_dvd   = Q_ONE - d_r;
        div_dvs   = deg;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign sqrt_start = (state_r == S_SQRT_GO);

  pr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Lane control and operands
  always_comb begin
    lctl.mul_en  = (state_r == S_MAC) || (state_r == S_SQ);
    lctl.acc_clr = (state_r == S_COPY);
    lctl.acc_en  = mac_d_r;
  end

  for (genvar g = 0; g < CAP; g++) begin : g_lane
    assign lane_a[g] = (state_r == S_SQ) ? rank_r[g] : prev_r[cnt_r];
    assign lane_b[g] = (state_r == S_SQ) ? rank_r[g] :
                       (adj_r[cnt_r][g] ? pt_r[cnt_r] : tele_r);

    pr_lane u_lane (
      .clk  (clk),
      .ctrl (lctl),
      .op_a (lane_a[g]),
      .op_b (lane_b[g]),
      .prod (lane_prod[g]),
      .acc  (lane_acc[g])
    );
  end

  // Norm merge, convergence test and selection compare
  always_comb begin
    sum_add   = {1'b0, sum_r} + {1'b0, lane_prod[cnt_r]};
    norm_diff = (new_norm_r > old_norm_r) ? new_norm_r - old_norm_r
                                          : old_norm_r - new_norm_r;
    stop_now  = (norm_diff <= cfg_tol_r) || (iter_r >= limit_r);
    take      = !used_r[cnt_r] && (!found_r || (rank_r[cnt_r] > best_val_r));
  end

  // Next-state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (in_xfer && in_last_row) state_nxt = S_CHECK;
      S_CHECK:      state_nxt = empty_hit ? S_WAIT_OUT : S_TELE_GO;
      S_TELE_GO:    state_nxt = S_TELE_WAIT;
      S_TELE_WAIT:  if (div_done) state_nxt = S_START_GO;
      S_START_GO:   state_nxt = S_START_WAIT;
      S_START_WAIT: if (div_done) state_nxt = S_EDGE_GO;
      S_EDGE_GO:    state_nxt = S_EDGE_WAIT;
      S_EDGE_WAIT:  if (div_done) state_nxt = last_cnt ? S_SQ : S_EDGE_GO;
      S_SQ:         state_nxt = S_SUM;
      S_SUM:        if (last_cnt) state_nxt = S_SQRT_GO;
      S_SQRT_GO:    state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT:  if (sqrt_done) state_nxt = first_r ? S_COPY : S_DECIDE;
      S_DECIDE:     state_nxt = stop_now ? S_AVG : S_COPY;
      S_COPY:       state_nxt = S_MAC;
      S_MAC:        if (last_cnt) state_nxt = S_MAC_DRAIN;
      S_MAC_DRAIN:  state_nxt = S_SAT;
      S_SAT:        state_nxt = S_SQ;
      S_AVG:        state_nxt = S_SCAN;
      S_SCAN:       if (last_cnt) state_nxt = S_EMIT;
      S_EMIT:       state_nxt = S_WAIT_OUT;
      S_WAIT_OUT:   if (out_xfer) state_nxt = out_last_r ? S_IDLE : S_SCAN;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_nodes_r <= RST_NODES;
      cfg_tele_r  <= RST_TELEPORT;
      cfg_tol_r   <= RST_TOLERANCE;
      cfg_limit_r <= RST_LIMIT;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      mac_d_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mac_d_r <= (state_r == S_MAC);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: cfg_nodes_r <= cfg_data[NODE_W-1:0];
          CFG_TELEPORT:   cfg_tele_r  <= cfg_data;
          CFG_TOLERANCE:  cfg_tol_r   <= cfg_data;
          CFG_ITER_LIMIT: cfg_limit_r <= cfg_data[ITER_W-1:0];
          default:        cfg_tele_r  <= cfg_tele_r;
        endcase
      end
      if (state_r == S_CHECK || state_r == S_START_GO) begin
        iter_r <= '0;
      end else if (state_r == S_SAT) begin
        iter_r <= iter_r + ITER_W'(1);
      end
      if (state_r == S_CHECK && empty_hit) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Store incoming rows
    if (in_xfer && ({1'b0, in_row_index} < CAP_N)) begin
      adj_r[in_row_index[IDX_W-1:0]] <= in_row_bits;
    end

    unique case (state_r)
      S_IDLE: begin
        n_r     <= n_clamp;
        nm1_r   <= IDX_W'(n_clamp - NODE_W'(1));
        d_r     <= d_clamp;
        limit_r <= (cfg_limit_r == '0) ? ITER_W'(1) : cfg_limit_r;
        mask_r  <= mask_nxt;
      end
      S_CHECK: begin
        cnt_r        <= '0;
        first_r      <= 1'b1;
        out_vertex_r <= '0;
        out_rank_r   <= '0;
        out_iter_r   <= '0;
        out_lim_r    <= 1'b0;
        out_err_r    <= 1'b1;
        out_last_r   <= 1'b1;
      end
      S_TELE_WAIT: begin
        if (div_done) tele_r <= div_q;
      end
      S_START_WAIT: begin
        if (div_done) begin
          for (int i = 0; i < CAP; i++) rank_r[i] <= div_q;
        end
      end
      S_EDGE_WAIT: begin
        if (div_done) begin
          pt_r[cnt_r] <= div_q + tele_r;
          cnt_r       <= last_cnt ? '0 : cnt_r + IDX_W'(1);
        end
      end
      S_SQ: begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      S_SUM: begin
        // Saturate the sum of squares
        sum_r <= sum_add[PROD_W] ? {PROD_W{1'b1}} : sum_add[PROD_W-1:0];
        cnt_r <= last_cnt ? '0 : cnt_r + IDX_W'(1);
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (first_r) old_norm_r <= sqrt_root;
          else         new_norm_r <= sqrt_root;
          first_r <= 1'b0;
        end
      end
      S_DECIDE: begin
        old_norm_r <= new_norm_r;
        limited_r  <= (iter_r == limit_r);
        cnt_r      <= '0;
      end
      S_COPY: begin
        for (int i = 0; i < CAP; i++) prev_r[i] <= rank_r[i];
        cnt_r <= '0;
      end
      S_MAC: begin
        cnt_r <= last_cnt ? '0 : cnt_r + IDX_W'(1);
      end
      S_SAT: begin
        for (int i = 0; i < CAP; i++) begin
          rank_r[i] <= (lane_acc[i] > {{(ACC_W-VAL_W){1'b0}}, Q_ONE}) ? Q_ONE
                                                                    : lane_acc[i][VAL_W-1:0];
        end
      end
      S_AVG: begin
        // Average the last two vectors at the limit
        if (limited_r) begin
          for (int i = 0; i < CAP; i++) begin
            rank_r[i] <= VAL_W'(({1'b0, rank_r[i]} + {1'b0, prev_r[i]}) >> 1);
          end
        end
        used_r  <= '0;
        found_r <= 1'b0;
        cnt_r   <= '0;
        k_r     <= '0;
      end
      S_SCAN: begin
        if (take) begin
          found_r    <= 1'b1;
          best_r     <= cnt_r;
          best_val_r <= rank_r[cnt_r];
        end
        cnt_r <= last_cnt ? '0 : cnt_r + IDX_W'(1);
      end
      S_EMIT: begin
        used_r[best_r] <= 1'b1;
        out_vertex_r   <= VTX_W'(best_r);
        out_rank_r     <= best_val_r;
        out_iter_r     <= iter_r;
        out_lim_r      <= limited_r;
        out_err_r      <= 1'b0;
        out_last_r     <= (k_r == nm1_r);
      end
      S_WAIT_OUT: begin
        if (out_xfer) begin
          k_r     <= k_r + IDX_W'(1);
          found_r <= 1'b0;
          cnt_r   <= '0;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_vertex          = out_vertex_r;
  assign out_rank_value      = out_rank_r;
  assign out_iterations_used = out_iter_r;
  assign out_limit_reached   = out_lim_r;
  assign out_empty_row_error = out_err_r;
  assign out_last_result     = out_last_r;

endmodule
